// ===== sv/srgb_lg_pkg.sv =====
// srgb_lg_pkg: shared constants and the sRGB decode table function for the grey converter
// depends on nothing; used by srgb_lg_luma, srgb_lg_encode and the top level
`default_nettype none

package srgb_lg_pkg;

    // pixel and result widths
    localparam int CHAN_W   = 8;
    localparam int GREY_W   = 8;
    localparam int CODES    = 256;

    // Rec.709 weights as 0.16 fractions, summing to exactly one
    localparam int          WEIGHT_W = 16;
    localparam logic [15:0] W_RED    = 16'd13932;
    localparam logic [15:0] W_GREEN  = 16'd46872;
    localparam logic [15:0] W_BLUE   = 16'd4732;

    // decode curve constants in rational form
    localparam int LIN_KNEE   = 10;     // last code on the linear segment
    localparam int SLOPE_NUM  = 5;      // c/(255*12.92) = 5c/16473
    localparam int SLOPE_DEN  = 16473;
    localparam int GAMMA_STEP = 40;     // (c/255+0.055)/1.055 = (40c+561)/10761
    localparam int GAMMA_OFS  = 561;
    localparam int GAMMA_DEN  = 10761;
    localparam int POW_NUM    = 12;     // exponent 2.4 = 12/5
    localparam int POW_DEN    = 5;

    // widest table entry (fraction bits up to 32, plus the value one)
    localparam int LIN_MAX_W  = 33;
    // wide enough for 10761^12 * y^5 and num^12 * 2^(5*32)
    localparam int BIG_W      = 336;

    // exact floor of 2^frac * decode(code); evaluated at elaboration only
    function automatic logic [LIN_MAX_W-1:0] lin_entry(input int unsigned code,
                                                       input int unsigned frac);
        logic [BIG_W-1:0]     den_pow;
        logic [BIG_W-1:0]     num_pow;
        logic [BIG_W-1:0]     trial;
        logic [LIN_MAX_W-1:0] lo;
        logic [LIN_MAX_W-1:0] hi;
        logic [LIN_MAX_W-1:0] mid;
        logic [LIN_MAX_W-1:0] result;
        den_pow = BIG_W'(1);
        num_pow = BIG_W'(1);
        trial   = '0;
        lo      = '0;
        hi      = '0;
        mid     = '0;
        if (code <= LIN_KNEE)
        begin
            num_pow = (BIG_W'(code) * BIG_W'(SLOPE_NUM)) << frac;
            result  = LIN_MAX_W'(num_pow / BIG_W'(SLOPE_DEN));
        end
        else if (code == CODES - 1)
        begin
            result = LIN_MAX_W'(1) << frac;
        end
        else
        begin
            for (int k = 0; k < POW_NUM; k++)
            begin
                den_pow = den_pow * BIG_W'(GAMMA_DEN);
                num_pow = num_pow * BIG_W'(GAMMA_STEP * code + GAMMA_OFS);
            end
            num_pow = num_pow << (POW_DEN * frac);
            hi = (LIN_MAX_W'(1) << frac) - LIN_MAX_W'(1);
            // largest y with y^5 * den^12 <= num^12 * 2^(5*frac)
            for (int it = 0; it < LIN_MAX_W; it++)
            begin
                if (lo < hi)
                begin
                    mid   = lo + ((hi - lo + LIN_MAX_W'(1)) >> 1);
                    trial = den_pow;
                    for (int p = 0; p < POW_DEN; p++)
                    begin
                        trial = trial * BIG_W'(mid);
                    end
                    if (trial <= num_pow)
                    begin
                        lo = mid;
                    end
                    else
                    begin
                        hi = mid - LIN_MAX_W'(1);
                    end
                end
            end
            result = lo;
        end
        return result;
    endfunction

endpackage

`default_nettype wire

// ===== sv/srgb_luminance_grayscale.sv =====
// srgb_luminance_grayscale: sRGB pixel to Rec.709 relative-luminance grey level, top level
// depends on srgb_lg_pkg, srgb_lg_luma and srgb_lg_encode
//
// Takes one 8-bit RGB pixel per clock and returns one 8-bit grey level, exact to the
// truncated sRGB re-encoding of the Rec.709 luminance. A request is taken on every
// cycle with start high; busy never rises. Each result appears on grey_value for one
// cycle with done high, in request order, once it has passed the pipeline; the receiver
// must take it then. The pipeline is the input register, the product register, the sum
// register, then one search stage per grey bit against the decode table.
// No clearing pass; results are valid from the first request after reset.
`default_nettype none

module srgb_luminance_grayscale #(
    parameter int FRAC_BITS = 20
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [srgb_lg_pkg::CHAN_W-1:0]     red_value,
    input  wire logic [srgb_lg_pkg::CHAN_W-1:0]     green_value,
    input  wire logic [srgb_lg_pkg::CHAN_W-1:0]     blue_value,
    output logic                                    done,
    output logic [srgb_lg_pkg::GREY_W-1:0]          grey_value
);

    localparam int SW      = FRAC_BITS + srgb_lg_pkg::WEIGHT_W + 3;
    localparam int LATENCY = 3 + srgb_lg_pkg::GREY_W;

    logic          accept;
    logic          lum_valid;
    logic [SW-1:0] lum;

    // fully pipelined, never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // decode, weight and sum
    srgb_lg_luma #(
        .FRAC_BITS (FRAC_BITS)
    ) u_luma (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .red_value   (red_value),
        .green_value (green_value),
        .blue_value  (blue_value),
        .lum_valid   (lum_valid),
        .lum         (lum)
    );

    // re-encode to grey
    srgb_lg_encode #(
        .FRAC_BITS (FRAC_BITS)
    ) u_encode (
        .clk        (clk),
        .rst_n      (rst_n),
        .lum_valid  (lum_valid),
        .lum        (lum),
        .grey_valid (done),
        .grey_value (grey_value)
    );

    // every result traces back to an earlier request
    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result strobe without a matching request");

    // every request gives a result at the pipeline output
    a_request_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("request lost in the pipeline");

    // a neutral pixel maps back to its own code
    a_neutral_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (red_value == green_value) && (green_value == blue_value))
        |-> ##LATENCY (grey_value == $past(red_value, LATENCY)))
        else $error("neutral pixel did not map to itself");

endmodule

`default_nettype wire

// ===== sv/srgb_lg_luma.sv =====
// srgb_lg_luma: input register, sRGB decode lookups, weighting and luminance sum
// depends on srgb_lg_pkg (decode table function, weights)
`default_nettype none

module srgb_lg_luma #(
    parameter int FRAC_BITS = 20
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          accept,
    input  wire logic [srgb_lg_pkg::CHAN_W-1:0]                red_value,
    input  wire logic [srgb_lg_pkg::CHAN_W-1:0]                green_value,
    input  wire logic [srgb_lg_pkg::CHAN_W-1:0]                blue_value,
    output logic                                               lum_valid,
    output logic [FRAC_BITS+srgb_lg_pkg::WEIGHT_W+2:0]         lum
);

    localparam int LW = FRAC_BITS + 1;
    localparam int PW = LW + srgb_lg_pkg::WEIGHT_W;
    localparam int SW = PW + 2;

    // decode table, built at elaboration
    logic [LW-1:0] lin_rom [srgb_lg_pkg::CODES];

    for (genvar c = 0; c < srgb_lg_pkg::CODES; c++)
    begin : g_rom
        localparam logic [srgb_lg_pkg::LIN_MAX_W-1:0] ENTRY =
            srgb_lg_pkg::lin_entry(c, FRAC_BITS);
        assign lin_rom[c] = ENTRY[LW-1:0];
    end

    logic [2:0]                      vld_reg;
    logic [2:0]                      vld_next;
    logic [srgb_lg_pkg::CHAN_W-1:0]  red_reg;
    logic [srgb_lg_pkg::CHAN_W-1:0]  green_reg;
    logic [srgb_lg_pkg::CHAN_W-1:0]  blue_reg;
    logic [PW-1:0]                   prod_r_reg;
    logic [PW-1:0]                   prod_g_reg;
    logic [PW-1:0]                   prod_b_reg;
    logic [PW-1:0]                   prod_r_next;
    logic [PW-1:0]                   prod_g_next;
    logic [PW-1:0]                   prod_b_next;
    logic [SW-1:0]                   sum_reg;
    logic [SW-1:0]                   sum_next;

    // stage valids: input, products, sum
    assign vld_next = {vld_reg[1:0], accept};

    // weighted linear values
    assign prod_r_next = PW'(lin_rom[red_reg])   * PW'(srgb_lg_pkg::W_RED);
    assign prod_g_next = PW'(lin_rom[green_reg]) * PW'(srgb_lg_pkg::W_GREEN);
    assign prod_b_next = PW'(lin_rom[blue_reg])  * PW'(srgb_lg_pkg::W_BLUE);

    // luminance in unsigned 3.(FRAC_BITS+16) format, at most one
    assign sum_next = SW'(prod_r_reg) + SW'(prod_g_reg) + SW'(prod_b_reg);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            red_reg   <= red_value;
            green_reg <= green_value;
            blue_reg  <= blue_value;
        end
        prod_r_reg <= prod_r_next;
        prod_g_reg <= prod_g_next;
        prod_b_reg <= prod_b_next;
        sum_reg    <= sum_next;
    end

    assign lum_valid = vld_reg[2];
    assign lum       = sum_reg;

endmodule

`default_nettype wire

// ===== sv/srgb_lg_encode.sv =====
// srgb_lg_encode: re-encoding of luminance to a grey code by a pipelined binary search
// depends on srgb_lg_pkg (decode table function, widths)
`default_nettype none

module srgb_lg_encode #(
    parameter int FRAC_BITS = 20
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      lum_valid,
    input  wire logic [FRAC_BITS+srgb_lg_pkg::WEIGHT_W+2:0] lum,
    output logic                                           grey_valid,
    output logic [srgb_lg_pkg::GREY_W-1:0]                 grey_value
);

    localparam int LW = FRAC_BITS + 1;
    localparam int SW = LW + srgb_lg_pkg::WEIGHT_W + 2;
    localparam int GW = srgb_lg_pkg::GREY_W;

    // decode table; boundary k is entry k shifted up by the weight fraction
    logic [LW-1:0] lin_rom [srgb_lg_pkg::CODES];

    for (genvar c = 0; c < srgb_lg_pkg::CODES; c++)
    begin : g_rom
        localparam logic [srgb_lg_pkg::LIN_MAX_W-1:0] ENTRY =
            srgb_lg_pkg::lin_entry(c, FRAC_BITS);
        assign lin_rom[c] = ENTRY[LW-1:0];
    end

    logic [GW-1:0] vld_reg;
    logic [GW-1:0] vld_next;
    logic [SW-1:0] lum_reg   [GW];
    logic [SW-1:0] lum_next  [GW];
    logic [GW-1:0] grey_reg  [GW];
    logic [GW-1:0] grey_next [GW];

    // one result bit per stage, most significant first
    always_comb
    begin
        logic [SW-1:0] lum_in;
        logic [GW-1:0] grey_in;
        logic          vld_in;
        logic [GW-1:0] probe;
        logic [SW-1:0] bound;
        for (int s = 0; s < GW; s++)
        begin
            if (s == 0)
            begin
                lum_in  = lum;
                grey_in = '0;
                vld_in  = lum_valid;
            end
            else
            begin
                lum_in  = lum_reg[s-1];
                grey_in = grey_reg[s-1];
                vld_in  = vld_reg[s-1];
            end
            probe = grey_in | (GW'(1) << (GW - 1 - s));
            bound = SW'(lin_rom[probe]) << srgb_lg_pkg::WEIGHT_W;
            lum_next[s]  = lum_in;
            grey_next[s] = (lum_in >= bound) ? probe : grey_in;
            vld_next[s]  = vld_in;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        lum_reg  <= lum_next;
        grey_reg <= grey_next;
    end

    assign grey_valid = vld_reg[GW-1];
    assign grey_value = grey_reg[GW-1];

endmodule

`default_nettype wire
